[hdl/lru_page_replacement_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpr: same-cycle check failed");

// Delayed form of the implication check: the consequent must hold after the antecedent.
`define LPR_ASSERT_DLY2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("lpr: delayed check failed");

`endif

[hdl/lpr_pkg.sv]
package lpr_pkg;

  localparam int unsigned PageW  = 16;
  localparam int unsigned FaultW = 16;
  localparam int unsigned CfgW   = 4;

  localparam logic [CfgW-1:0]   CfgReset = 4'd4;
  localparam logic [FaultW-1:0] FaultMax = 16'hFFFF;

  typedef struct packed {
    logic [PageW-1:0] page_number;
    logic             last_reference;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PageW-1:0]  evicted_page;
    logic [FaultW-1:0] fault_count;
    logic              run_done;
  } rsp_t;

  // Outcome of one lookup in the frame list.
  typedef struct packed {
    logic             hit;
    logic             evicted_valid;
    logic [PageW-1:0] evicted_page;
  } lookup_t;

endpackage

[hdl/lpr_frame_list.sv]
module lpr_frame_list #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  lpr_pkg::req_t               req_i,
  input  logic [lpr_pkg::CfgW-1:0]    frames_in_use_i,
  output lpr_pkg::lookup_t            lookup_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CmpW = (CntW > lpr_pkg::CfgW) ? CntW : lpr_pkg::CfgW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_FRAMES);

  logic [lpr_pkg::PageW-1:0] frames_q [MAX_FRAMES];
  logic [lpr_pkg::PageW-1:0] frames_d [MAX_FRAMES];
  logic [CntW-1:0]           count_q, count_d;

  logic [MAX_FRAMES-1:0] match;
  logic [CntW-1:0]       pos;
  logic [CntW-1:0]       shift_end;
  logic [CntW-1:0]       lim;
  logic [CmpW-1:0]       cfg_ext;
  logic                  full;
  logic [CntW-1:0]       tail;
  logic [IdxW-1:0]       tail_idx;

  // Effective frame limit: zero acts as one, large values clamp to the array.
  always_comb begin
    cfg_ext = CmpW'(frames_in_use_i);
    if (cfg_ext == '0) begin
      lim = CntW'(1);
    end else if (cfg_ext >= MaxCmp) begin
      lim = CntW'(MAX_FRAMES);
    end else begin
      lim = cfg_ext[CntW-1:0];
    end
  end

  // Compare every occupied slot at once; the lowest matching slot wins.
  always_comb begin
    pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      match[i] = (CntW'(i) < count_q) && (frames_q[i] == req_i.page_number);
      if (match[i]) begin
        pos = CntW'(i);
      end
    end
  end

  assign full     = (count_q >= lim);
  assign tail     = count_q - CntW'(1);
  assign tail_idx = tail[IdxW-1:0];

  always_comb begin
    lookup_o.hit           = |match;
    lookup_o.evicted_valid = 1'b0;
    lookup_o.evicted_page  = '0;
    count_d                = count_q;
    if (lookup_o.hit) begin
      shift_end = pos;
    end else if (full) begin
      shift_end              = tail;
      lookup_o.evicted_valid = 1'b1;
      lookup_o.evicted_page  = frames_q[tail_idx];
    end else begin
      shift_end = count_q;
      count_d   = count_q + CntW'(1);
    end
    if (req_i.last_reference) begin
      count_d = '0;
    end
  end

  // Slots up to the shift end move down by one; the new page goes to the front.
  always_comb begin
    frames_d[0] = req_i.page_number;
    for (int i = 1; i < MAX_FRAMES; i++) begin
      frames_d[i] = (CntW'(i) <= shift_end) ? frames_q[i-1] : frames_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frames_q[i] <= frames_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (valid_i) begin
      count_q <= count_d;
    end
  end

endmodule

[hdl/lpr_fault_counter.sv]
module lpr_fault_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        miss_i,
  input  logic                        clear_i,
  output logic [lpr_pkg::FaultW-1:0]  count_o
);

  logic [lpr_pkg::FaultW-1:0] faults_q, faults_d;

  // Count including the current beat, held at the maximum.
  always_comb begin
    count_o = faults_q;
    if (miss_i && (faults_q != lpr_pkg::FaultMax)) begin
      count_o = faults_q + lpr_pkg::FaultW'(1);
    end
    faults_d = clear_i ? '0 : count_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q <= '0;
    end else if (valid_i) begin
      faults_q <= faults_d;
    end
  end

endmodule

[hdl/lru_page_replacement.sv]
// The result of a reference passes the input register and then the result register
// before it reaches the ports; the receiver cannot stall it.
// Throughput: one reference per cycle; busy_o is never raised.
// The frame compare and reorder are combinational between the two registers.
// Reset clears the resident count, the fault counter and the pipeline valid bits,
// and sets the frame limit to four; frame contents are not cleared.
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command side.
  input  logic                        start_i,
  input  lpr_pkg::req_t               item_i,
  output logic                        busy_o,
  // Frame limit register.
  input  logic                        cfg_we_i,
  input  logic [lpr_pkg::CfgW-1:0]    cfg_wdata_i,
  // Result side, one strobe per beat.
  output logic                        result_valid_o,
  output lpr_pkg::rsp_t               result_o
);

  // The block never stalls the command side: each beat's state update is
  // finished in the cycle after it is captured, so the next beat can follow
  // directly behind it and already sees the updated frame list.
  assign busy_o = 1'b0;

  logic [lpr_pkg::CfgW-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpr_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Input register: one beat of command payload plus its valid bit.
  lpr_pkg::req_t req_q;
  logic          req_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= item_i;
    end
  end

  // Lookup, reorder and eviction over the resident frames.
  lpr_pkg::lookup_t lookup;

  lpr_frame_list #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_frame_list (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (req_vld_q),
    .req_i          (req_q),
    .frames_in_use_i(cfg_q),
    .lookup_o       (lookup)
  );

  // Every miss counts as a fault; the run's last beat clears the counter
  // only after its own result has picked up the count.
  logic [lpr_pkg::FaultW-1:0] fault_count;

  lpr_fault_counter u_fault_counter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_vld_q),
    .miss_i (!lookup.hit),
    .clear_i(req_q.last_reference),
    .count_o(fault_count)
  );

  // Result register. The receiver cannot push back, so the strobe lasts
  // exactly one cycle per beat.
  lpr_pkg::rsp_t rsp_d, rsp_q;
  logic          rsp_vld_q;

  always_comb begin
    rsp_d.hit           = lookup.hit;
    rsp_d.evicted_valid = lookup.evicted_valid;
    rsp_d.evicted_page  = lookup.evicted_page;
    rsp_d.fault_count   = fault_count;
    rsp_d.run_done      = req_q.last_reference;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = rsp_vld_q;
  assign result_o       = rsp_q;

endmodule

[hdl/lpr_checker.sv]
`include "lru_page_replacement_assert.svh"

module lpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          result_valid_o,
  input lpr_pkg::rsp_t result_o
);

  // Every accepted beat produces its strobe once it has passed the input and result registers.
  `LPR_ASSERT_DLY2(a_beat_gives_result, start_i && !busy_o, result_valid_o)
  // An eviction only ever happens on a fault.
  `LPR_ASSERT_IMP(a_evict_on_miss, result_valid_o && result_o.evicted_valid, !result_o.hit)
  // Without an eviction the evicted page reads as zero.
  `LPR_ASSERT_IMP(a_no_evict_zero, result_valid_o && !result_o.evicted_valid, result_o.evicted_page == '0)
  // A fault always leaves a nonzero count in the result.
  `LPR_ASSERT_IMP(a_fault_counted, result_valid_o && !result_o.hit, result_o.fault_count != '0)

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
